// File: hdl/pmrp_pkg.sv
// Package for the power meter reply parser: frame constants, status codes,
// the frame record passed from front to back, and the CRC-16 byte step.
// No dependencies.
package pmrp_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int HEADER_LEN    = 3;
    localparam int CRC_LEN       = 2;
    localparam int MIN_FRAME     = HEADER_LEN + PAYLOAD_BYTES + CRC_LEN;
    localparam int SHORT_LIMIT   = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int WORD_W     = 16;
    localparam int PAIR_W     = 30;
    localparam int PAIR_SCALE = 10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND   = 1'd1;

    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd248;
    localparam logic [7:0] READ_COMMAND_RST   = 8'd4;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CRC   = 3'd2,
        ST_ADDR  = 3'd3,
        ST_CMD   = 3'd4,
        ST_COUNT = 3'd5
    } status_t;

    typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

    typedef struct packed {
        status_t  status;
        payload_t payload;
    } frame_rec_t;

    typedef struct packed {
        logic       valid;
        frame_rec_t rec;
    } rec_push_t;

    localparam int REC_W = $bits(frame_rec_t);

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hdl/pmrp_front.sv
// Front end of the reply parser: holds the config registers, takes frame bytes,
// runs the CRC, stores header and payload and classifies the frame on its last byte.
// Depends on pmrp_pkg.
module pmrp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [7:0]                          rx_byte,
    input  logic                                frame_end,
    input  logic                                cfg_wr_en,
    input  logic [pmrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmrp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output pmrp_pkg::rec_push_t                 rec_push
);

    logic [7:0]              dev_addr_reg;
    logic [7:0]              read_cmd_reg;
    logic [15:0]             crc_reg;
    logic [15:0]             crc_next;
    logic [1:0][7:0]         tail_reg;
    logic [7:0]              byte_index_reg;
    logic [7:0]              byte_index_next;
    logic [pmrp_pkg::HEADER_LEN-1:0][7:0] header_reg;
    pmrp_pkg::payload_t      payload_reg;
    logic [15:0]             crc_step;
    pmrp_pkg::status_t       status;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= pmrp_pkg::DEVICE_ADDRESS_RST;
            read_cmd_reg <= pmrp_pkg::READ_COMMAND_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pmrp_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg <= cfg_data;
                pmrp_pkg::CFG_READ_COMMAND:   read_cmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fold in the byte two places back; the last two bytes of a frame are the CRC
    always_comb
    begin
        if (byte_index_reg >= 8'd2)
            crc_step = pmrp_pkg::crc_byte(crc_reg, tail_reg[0]);
        else
            crc_step = crc_reg;
        crc_next = crc_step;
        if (byte_index_reg != 8'hFF)
            byte_index_next = byte_index_reg + 8'd1;
        else
            byte_index_next = byte_index_reg;
    end

    // Classify; first failing check wins
    always_comb
    begin
        if (byte_index_reg < 8'(pmrp_pkg::SHORT_LIMIT))
            status = pmrp_pkg::ST_SHORT;
        else if (tail_reg[1] != crc_step[7:0] || rx_byte != crc_step[15:8])
            status = pmrp_pkg::ST_CRC;
        else if (header_reg[0] != dev_addr_reg)
            status = pmrp_pkg::ST_ADDR;
        else if (header_reg[1] != read_cmd_reg)
            status = pmrp_pkg::ST_CMD;
        else if (header_reg[2] != 8'(pmrp_pkg::PAYLOAD_BYTES))
            status = pmrp_pkg::ST_COUNT;
        else if (byte_index_reg < 8'(pmrp_pkg::MIN_FRAME - 1))
            status = pmrp_pkg::ST_SHORT;
        else
            status = pmrp_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= pmrp_pkg::CRC_INIT;
            tail_reg       <= '0;
            byte_index_reg <= '0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                crc_reg        <= pmrp_pkg::CRC_INIT;
                tail_reg       <= '0;
                byte_index_reg <= '0;
            end
            else
            begin
                crc_reg        <= crc_next;
                tail_reg       <= {rx_byte, tail_reg[1]};
                byte_index_reg <= byte_index_next;
            end
        end
    end

    // Header and payload capture; each byte register decodes its own position
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int j = 0; j < pmrp_pkg::HEADER_LEN; j++)
            begin
                if (byte_index_reg == 8'(j))
                    header_reg[j] <= rx_byte;
            end
            for (int j = 0; j < pmrp_pkg::PAYLOAD_BYTES; j++)
            begin
                if (byte_index_reg == 8'(j + pmrp_pkg::HEADER_LEN))
                    payload_reg[j] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        rec_push.valid       = take && frame_end;
        rec_push.rec.status  = status;
        rec_push.rec.payload = payload_reg;
    end

endmodule

// File: hdl/pmrp_fifo.sv
// Short queue of classified frame records between front and back end.
// Depends on pmrp_pkg.
module pmrp_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmrp_pkg::rec_push_t   rec_push,
    input  logic                  q_pop,
    output pmrp_pkg::frame_rec_t  q_head,
    output logic                  q_empty,
    output logic                  q_full
);

    pmrp_pkg::frame_rec_t             mem [pmrp_pkg::QUEUE_DEPTH];
    logic [pmrp_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [pmrp_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [pmrp_pkg::QUEUE_CW-1:0]    count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == pmrp_pkg::QUEUE_CW'(pmrp_pkg::QUEUE_DEPTH));
    assign do_push = rec_push.valid && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= rec_push.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == pmrp_pkg::QUEUE_AW'(pmrp_pkg::QUEUE_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + pmrp_pkg::QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == pmrp_pkg::QUEUE_AW'(pmrp_pkg::QUEUE_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + pmrp_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + pmrp_pkg::QUEUE_CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - pmrp_pkg::QUEUE_CW'(1);
        end
    end

endmodule

// File: hdl/pmrp_back.sv
// Back end of the reply parser: turns a frame record into readings over two
// stages (scale high words, then add low words) and holds the result for pop.
// Depends on pmrp_pkg.
module pmrp_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pmrp_pkg::frame_rec_t              q_head,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  logic                              pop,
    output logic                              empty,
    output logic [2:0]                        frame_status,
    output logic [pmrp_pkg::WORD_W-1:0]       volts_tenths,
    output logic [pmrp_pkg::PAIR_W-1:0]       current_milli,
    output logic [pmrp_pkg::PAIR_W-1:0]       power_tenths,
    output logic [pmrp_pkg::PAIR_W-1:0]       energy_units,
    output logic [pmrp_pkg::WORD_W-1:0]       freq_tenths,
    output logic [pmrp_pkg::WORD_W-1:0]       pf_hundredths
);

    localparam int NPAIR = 3;

    logic                                   s1_valid_reg;
    pmrp_pkg::status_t                      s1_status_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s1_volts_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s1_freq_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s1_pf_reg;
    logic [NPAIR-1:0][pmrp_pkg::WORD_W-1:0] s1_low_reg;
    logic [NPAIR-1:0][pmrp_pkg::PAIR_W-1:0] s1_prod_reg;

    logic                                   s2_valid_reg;
    pmrp_pkg::status_t                      s2_status_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s2_volts_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s2_freq_reg;
    logic [pmrp_pkg::WORD_W-1:0]            s2_pf_reg;
    logic [NPAIR-1:0][pmrp_pkg::PAIR_W-1:0] s2_pair_reg;

    logic                                   s1_ready;
    logic                                   s2_ready;
    logic [NPAIR-1:0][pmrp_pkg::WORD_W-1:0] low_word;
    logic [NPAIR-1:0][pmrp_pkg::WORD_W-1:0] high_word;
    logic                                   s1_ok;

    // Advance a stage when the one after it is free or drains this cycle
    assign s2_ready = !s2_valid_reg || pop;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = s1_ready && !q_empty;

    // Pairs start at payload bytes 2, 6 and 10: low word then high word
    always_comb
    begin
        for (int p = 0; p < NPAIR; p++)
        begin
            low_word[p]  = {q_head.payload[2 + 4*p], q_head.payload[3 + 4*p]};
            high_word[p] = {q_head.payload[4 + 4*p], q_head.payload[5 + 4*p]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_status_reg <= q_head.status;
            s1_volts_reg  <= {q_head.payload[0], q_head.payload[1]};
            s1_freq_reg   <= {q_head.payload[14], q_head.payload[15]};
            s1_pf_reg     <= {q_head.payload[16], q_head.payload[17]};
            for (int p = 0; p < NPAIR; p++)
            begin
                s1_low_reg[p]  <= low_word[p];
                s1_prod_reg[p] <= pmrp_pkg::PAIR_W'(high_word[p])
                                * pmrp_pkg::PAIR_W'(pmrp_pkg::PAIR_SCALE);
            end
        end
    end

    // Zero every reading of a failed frame
    assign s1_ok = (s1_status_reg == pmrp_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_volts_reg  <= s1_ok ? s1_volts_reg : '0;
            s2_freq_reg   <= s1_ok ? s1_freq_reg : '0;
            s2_pf_reg     <= s1_ok ? s1_pf_reg : '0;
            for (int p = 0; p < NPAIR; p++)
            begin
                s2_pair_reg[p] <= s1_ok
                    ? (pmrp_pkg::PAIR_W'(s1_low_reg[p]) + s1_prod_reg[p]) : '0;
            end
        end
    end

    assign empty         = !s2_valid_reg;
    assign frame_status  = s2_status_reg;
    assign volts_tenths  = s2_volts_reg;
    assign current_milli = s2_pair_reg[0];
    assign power_tenths  = s2_pair_reg[1];
    assign energy_units  = s2_pair_reg[2];
    assign freq_tenths   = s2_freq_reg;
    assign pf_hundredths = s2_pf_reg;

endmodule

// File: hdl/power_meter_reply_parser.sv
// Power meter reply parser: in-order frame bytes in, one status and reading item
// out per frame. Depends on pmrp_pkg, pmrp_front, pmrp_fifo and pmrp_back.
//
// Usage:
//   Input side is a queue: drive rx_byte and frame_end (high on the frame's
//   last byte) and raise push; the item is taken at an edge with push high
//   and full low. One byte per clock is sustained; full rises only when four
//   classified frames wait in the middle queue and the result side is stalled.
//   Result side is a queue too: while empty is low the oldest result is on
//   frame_status and the reading ports; pop it at an edge with pop high.
//   The record of a frame's last byte is written to the middle queue, then moves
//   through the back-end registers s1 and s2. A new result can be popped every
//   cycle, so frames of any length stream through at one byte per cycle.
//   A stalled receiver holds the result steady; frames keep classifying into
//   the middle queue until it fills, and then full throttles the sender.
//   Failed frames report their status with all readings at zero.
//   Config: cfg_wr_en with cfg_index 0 (device address) or 1 (read command)
//   writes cfg_data at the edge; write only while no frame is in flight.
//   Reset: clears the frame state, the queues and restores address 248 and
//   command 4; no clearing pass is needed.
module power_meter_reply_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          rx_byte,
    input  logic                                frame_end,
    input  logic                                cfg_wr_en,
    input  logic [pmrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmrp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [2:0]                          frame_status,
    output logic [pmrp_pkg::WORD_W-1:0]         volts_tenths,
    output logic [pmrp_pkg::PAIR_W-1:0]         current_milli,
    output logic [pmrp_pkg::PAIR_W-1:0]         power_tenths,
    output logic [pmrp_pkg::PAIR_W-1:0]         energy_units,
    output logic [pmrp_pkg::WORD_W-1:0]         freq_tenths,
    output logic [pmrp_pkg::WORD_W-1:0]         pf_hundredths
);

    pmrp_pkg::rec_push_t   rec_push;
    pmrp_pkg::frame_rec_t  q_head;
    logic                  q_empty;
    logic                  q_full;
    logic                  q_pop;
    logic                  take;

    // Hold off every byte while the middle queue is full so a last byte always has a slot
    assign full = q_full;
    assign take = push && !q_full;

    pmrp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_push  (rec_push)
    );

    pmrp_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec_push (rec_push),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_full   (q_full)
    );

    pmrp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .frame_status  (frame_status),
        .volts_tenths  (volts_tenths),
        .current_milli (current_milli),
        .power_tenths  (power_tenths),
        .energy_units  (energy_units),
        .freq_tenths   (freq_tenths),
        .pf_hundredths (pf_hundredths)
    );

endmodule

// File: hdl/pmrp_checker.sv
// Port-level checker for the power meter reply parser, bound to the top level.
// Depends on pmrp_pkg and power_meter_reply_parser.
module pmrp_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             frame_end,
    input logic                             empty,
    input logic                             pop,
    input logic [2:0]                       frame_status,
    input logic [pmrp_pkg::WORD_W-1:0]      volts_tenths,
    input logic [pmrp_pkg::PAIR_W-1:0]      current_milli,
    input logic [pmrp_pkg::PAIR_W-1:0]      power_tenths,
    input logic [pmrp_pkg::PAIR_W-1:0]      energy_units,
    input logic [pmrp_pkg::WORD_W-1:0]      freq_tenths,
    input logic [pmrp_pkg::WORD_W-1:0]      pf_hundredths
);

    localparam logic [pmrp_pkg::PAIR_W-1:0] PAIR_MAX = pmrp_pkg::PAIR_W'(655415535);

    // A waiting result stays, with its status and current steady, until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_status) && $stable(current_milli)))
        else $error("result changed while waiting");

    // Failed frames carry no readings
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status != pmrp_pkg::ST_OK) |->
        (volts_tenths == '0 && current_milli == '0 && power_tenths == '0 &&
         energy_units == '0 && freq_tenths == '0 && pf_hundredths == '0))
        else $error("failed frame with nonzero readings");

    // Scaled pairs never exceed the largest low plus scaled high word
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (current_milli <= PAIR_MAX && power_tenths <= PAIR_MAX &&
                    energy_units <= PAIR_MAX))
        else $error("scaled reading out of range");

    // Only a frame's last byte can fill the queue
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && frame_end))
        else $error("full rose without a last byte");

endmodule

bind power_meter_reply_parser pmrp_checker u_pmrp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .frame_end     (frame_end),
    .empty         (empty),
    .pop           (pop),
    .frame_status  (frame_status),
    .volts_tenths  (volts_tenths),
    .current_milli (current_milli),
    .power_tenths  (power_tenths),
    .energy_units  (energy_units),
    .freq_tenths   (freq_tenths),
    .pf_hundredths (pf_hundredths)
);

// File: test/pmrp_tb_pkg.sv
`timescale 1ns / 100ps
// Checking side of the reply parser bench: the reading record, the CRC-16 step
// and the frame_checker scoreboard that predicts and compares results.
// Depends on pmrp_pkg for widths, frame constants and status codes.
package pmrp_tb_pkg;

    import pmrp_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZERO
    } fill_t;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   volts;
        logic [PAIR_W-1:0]   current;
        logic [PAIR_W-1:0]   power;
        logic [PAIR_W-1:0]   energy;
        logic [WORD_W-1:0]   freq;
        logic [WORD_W-1:0]   pf;
    } reading_t;

    // Reflected CRC-16, one input bit at a time, LSB first.
    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[15:1]};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    class frame_checker;

        logic [7:0]  dev_addr;
        logic [7:0]  rd_cmd;
        logic [15:0] crc_acc;
        logic [7:0]  last_two [2];
        logic [7:0]  pos_count;
        logic [7:0]  hdr [HEADER_LEN];
        logic [7:0]  data [PAYLOAD_BYTES];
        reading_t    expected_replies [$];
        int unsigned mismatches;

        function new();
            dev_addr   = DEVICE_ADDRESS_RST;
            rd_cmd     = READ_COMMAND_RST;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            crc_acc   = CRC_INIT;
            last_two  = '{8'h00, 8'h00};
            pos_count = 8'h00;
            foreach (hdr[i])
                hdr[i] = 8'h00;
            foreach (data[i])
                data[i] = 8'h00;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEVICE_ADDRESS: dev_addr = val;
                CFG_READ_COMMAND:   rd_cmd   = val;
                default: ;
            endcase
        endfunction

        function logic [WORD_W-1:0] word_of(int unsigned i);
            return {data[i], data[i + 1]};
        endfunction

        function logic [PAIR_W-1:0] pair_of(int unsigned i);
            logic [31:0] s;
            s = 32'(word_of(i)) + 32'(PAIR_SCALE) * 32'(word_of(i + 2));
            return s[PAIR_W-1:0];
        endfunction

        // Advance the frame state by one byte; on the last byte queue the reply.
        function void take_byte(logic [7:0] b, logic last);
            int unsigned p;
            int unsigned len;
            reading_t    r;
            p = pos_count;
            if (p < HEADER_LEN)
                hdr[p] = b;
            else if (p < HEADER_LEN + PAYLOAD_BYTES)
                data[p - HEADER_LEN] = b;
            // the CRC runs two bytes behind, so the trailer never enters it
            if (p >= 2)
                crc_acc = crc16_step(crc_acc, last_two[0]);
            last_two[0] = last_two[1];
            last_two[1] = b;
            if (!last)
            begin
                if (pos_count != 8'hFF)
                    pos_count++;
                return;
            end
            len = p + 1;
            r   = '0;
            if (len <= SHORT_LIMIT)
                r.status = ST_SHORT;
            else if (last_two[0] != crc_acc[7:0] || last_two[1] != crc_acc[15:8])
                r.status = ST_CRC;
            else if (hdr[0] != dev_addr)
                r.status = ST_ADDR;
            else if (hdr[1] != rd_cmd)
                r.status = ST_CMD;
            else if (hdr[2] != 8'(PAYLOAD_BYTES))
                r.status = ST_COUNT;
            else if (len < MIN_FRAME)
                r.status = ST_SHORT;
            else
            begin
                r.status  = ST_OK;
                r.volts   = word_of(0);
                r.current = pair_of(2);
                r.power   = pair_of(6);
                r.energy  = pair_of(10);
                r.freq    = word_of(14);
                r.pf      = word_of(16);
            end
            expected_replies.push_back(r);
            restart();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return;
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_reply(reading_t got);
            reading_t want;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d", got.status);
                return;
            end
            want = expected_replies.pop_front();
            compare_field("frame_status", want.status, got.status);
            compare_field("volts_tenths", want.volts, got.volts);
            compare_field("current_milli", want.current, got.current);
            compare_field("power_tenths", want.power, got.power);
            compare_field("energy_units", want.energy, got.energy);
            compare_field("freq_tenths", want.freq, got.freq);
            compare_field("pf_hundredths", want.pf, got.pf);
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

    endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the reply parser bench: clock, reset, frame generation and the
// tasks that drive both queue sides. Depends on pmrp_pkg, pmrp_tb_pkg and the RTL.
module tb_top;

    import pmrp_pkg::*;
    import pmrp_tb_pkg::*;

    // Cycles with no accepted item before the run is declared hung. The slowest
    // legal stretch is a random gap on one side plus a register update pause,
    // which stays far below this limit.
    localparam int STALL_LIMIT  = 1000;
    // Margin for the pipeline to drain once every queued result is checked.
    localparam int DRAIN_CYCLES = 8;
    // Random bytes per register setting; five settings give about 1400 items.
    localparam int PHASE_BYTES  = 220;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  frame_end = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [2:0]            frame_status;
    logic [WORD_W-1:0]     volts_tenths;
    logic [PAIR_W-1:0]     current_milli;
    logic [PAIR_W-1:0]     power_tenths;
    logic [PAIR_W-1:0]     energy_units;
    logic [WORD_W-1:0]     freq_tenths;
    logic [WORD_W-1:0]     pf_hundredths;

    frame_checker board;

    // Register values the generator aims well-formed frames at.
    logic [7:0]  dev_addr_now = DEVICE_ADDRESS_RST;
    logic [7:0]  rd_cmd_now   = READ_COMMAND_RST;
    // Suppress random idling on one side while set.
    bit          send_calm    = 1'b0;
    bit          take_calm    = 1'b0;
    int unsigned bytes_sent   = 0;

    power_meter_reply_parser i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .frame_status  (frame_status),
        .volts_tenths  (volts_tenths),
        .current_milli (current_milli),
        .power_tenths  (power_tenths),
        .energy_units  (energy_units),
        .freq_tenths   (freq_tenths),
        .pf_hundredths (pf_hundredths)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle with a chance of 36 in a hundred unless the side is held calm.
    function automatic bit stall(bit calm);
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Build one frame of len bytes: header, payload filler, then the CRC
    // low byte first. Optionally flip one bit anywhere to break the CRC.
    function automatic void make_frame(output byte_q_t f, input int unsigned len,
                                       input logic [7:0] a, input logic [7:0] c,
                                       input logic [7:0] n, input fill_t fill,
                                       input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  b;
        int unsigned pick;
        crc = CRC_INIT;
        f   = {};
        for (int unsigned i = 0; i + 2 < len; i++)
        begin
            case (i)
                0:       b = a;
                1:       b = c;
                2:       b = n;
                default: b = (fill == FILL_ONES) ? 8'hFF :
                             (fill == FILL_ZERO) ? 8'h00 : 8'($urandom);
            endcase
            f.push_back(b);
            crc = crc16_step(crc, b);
        end
        f.push_back(crc[7:0]);
        f.push_back(crc[15:8]);
        if (corrupt)
        begin
            pick    = $urandom_range(len - 1);
            f[pick] = f[pick] ^ 8'(1 << $urandom_range(7));
        end
    endfunction

    // Pick a frame: half are well formed, two fifths break exactly one check,
    // and a tenth are plain noise of random length.
    function automatic void random_frame(output byte_q_t f);
        int unsigned roll;
        int unsigned len;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [7:0]  n;
        fill_t       fill;
        bit          corrupt;
        roll    = $urandom_range(99);
        len     = MIN_FRAME;
        a       = dev_addr_now;
        c       = rd_cmd_now;
        n       = 8'(PAYLOAD_BYTES);
        fill    = FILL_RANDOM;
        corrupt = 1'b0;
        if (roll < 50)
        begin
            // trailing bytes past the payload still feed the CRC
            if ($urandom_range(4) == 0)
                len = MIN_FRAME + $urandom_range(1, 12);
            if ($urandom_range(9) == 0)
                fill = FILL_ONES;
            else if ($urandom_range(19) == 0)
                fill = FILL_ZERO;
        end
        else if (roll < 58)
            a = dev_addr_now ^ 8'($urandom_range(1, 255));
        else if (roll < 64)
            c = rd_cmd_now ^ 8'($urandom_range(1, 255));
        else if (roll < 72)
            n = 8'(PAYLOAD_BYTES) ^ 8'($urandom_range(1, 255));
        else if (roll < 80)
            len = $urandom_range(2, MIN_FRAME - 1);
        else if (roll < 90)
            corrupt = 1'b1;
        else
        begin
            f   = {};
            len = $urandom_range(1, 30);
            repeat (len)
                f.push_back(8'($urandom));
            return;
        end
        make_frame(f, len, a, c, n, fill, corrupt);
    endfunction

    // Offer one byte and hold it until the block takes it. Push stays high
    // afterward so back-to-back bytes need no second assignment in one step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (stall(send_calm))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        rx_byte   <= b;
        frame_end <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic run_random(input int unsigned amount);
        byte_q_t     f;
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < amount)
        begin
            random_frame(f);
            send_frame(f);
        end
    endtask

    // Drop push, wait for every queued result, then let the pipeline drain.
    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write both registers on consecutive edges; the enable stays high between.
    task automatic program_regs(input logic [7:0] a, input logic [7:0] c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= a;
        @(posedge clk);
        board.set_reg(CFG_DEVICE_ADDRESS, a);
        cfg_index <= CFG_READ_COMMAND;
        cfg_data  <= c;
        @(posedge clk);
        board.set_reg(CFG_READ_COMMAND, c);
        cfg_wr_en    <= 1'b0;
        dev_addr_now = a;
        rd_cmd_now   = c;
    endtask

    // Stimulus and final verdict.
    initial
    begin
        byte_q_t f;
        board = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset register values.
        // Single-byte frame: shortest possible, too short.
        send_byte(8'h00, 1'b1);
        // Five bytes with a valid header and CRC: still too short.
        make_frame(f, 5, dev_addr_now, rd_cmd_now, 8'(PAYLOAD_BYTES), FILL_RANDOM, 1'b0);
        send_frame(f);
        // Six bytes, CRC good, address zero: first length past the short check.
        make_frame(f, 6, 8'h00, rd_cmd_now, 8'(PAYLOAD_BYTES), FILL_ONES, 1'b0);
        send_frame(f);
        // Address right, command all ones.
        make_frame(f, 7, dev_addr_now, 8'hFF, 8'(PAYLOAD_BYTES), FILL_ZERO, 1'b0);
        send_frame(f);

        run_random(PHASE_BYTES);

        // Register extremes at zero.
        settle();
        program_regs(8'h00, 8'h00);
        run_random(PHASE_BYTES);

        // Register extremes at all ones, with both sides streaming flat out.
        settle();
        program_regs(8'hFF, 8'hFF);
        send_calm = 1'b1;
        take_calm = 1'b1;
        run_random(PHASE_BYTES);
        send_calm = 1'b0;
        take_calm = 1'b0;

        // Random setting plus one frame long enough to saturate the byte count.
        settle();
        program_regs(8'($urandom), 8'($urandom));
        make_frame(f, $urandom_range(260, 290), dev_addr_now, rd_cmd_now,
                   8'(PAYLOAD_BYTES), FILL_RANDOM, 1'b0);
        send_frame(f);
        run_random(PHASE_BYTES);

        settle();
        program_regs(8'($urandom), 8'($urandom));
        run_random(PHASE_BYTES);

        settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: sample the outputs as they stood before the edge, check the
    // item if it was taken, then pick pop for the next edge.
    initial
    begin
        reading_t seen;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.status  = status_t'(frame_status);
                seen.volts   = volts_tenths;
                seen.current = current_milli;
                seen.power   = power_tenths;
                seen.energy  = energy_units;
                seen.freq    = freq_tenths;
                seen.pf      = pf_hundredths;
                board.check_reply(seen);
            end
            pop <= !stall(take_calm);
        end
    end

    // Watchdog: reset the count on any accepted item on either side.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
